// ===== rtl/core/pdrl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pdrl_pkg;

	// ledger geometry
	localparam int DEVICES      = 4;
	localparam int HOLDER_SLOTS = 16;
	localparam int NUM_CAP      = 4;

	// field widths
	localparam int MB_W      = 20;
	localparam int HOLDER_W  = 8;
	localparam int DEV_W     = 2;
	localparam int CNT_W     = 5;
	localparam int CFG_AW    = 4;
	localparam int SLOT_W    = (HOLDER_SLOTS > 1) ? $clog2(HOLDER_SLOTS) : 1;
	localparam int DEV_IDX_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;

	typedef enum logic [1:0] {
		OP_RESERVE = 2'd0,
		OP_RELEASE = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STS_OK      = 3'd0,
		STS_EMPTY   = 3'd1,
		STS_OVER    = 3'd2,
		STS_FULL    = 3'd3,
		STS_UNKNOWN = 3'd4
	} status_t;

	typedef logic [NUM_CAP-1:0][MB_W-1:0] cap_arr_t;

	// search record that travels down the cell chain
	typedef struct packed {
		logic                 vld;
		logic [DEV_IDX_W-1:0] dev;
		logic [HOLDER_W-1:0]  who;
		logic                 hit;
		logic [SLOT_W-1:0]    hit_idx;
		logic [MB_W-1:0]      hit_amt;
		logic                 free_ok;
		logic [SLOT_W-1:0]    free_idx;
		logic [CNT_W-1:0]     cnt;
	} srch_t;

	// slot update broadcast to every cell
	typedef struct packed {
		logic                 en;
		logic                 clr_all;
		logic [DEV_IDX_W-1:0] dev;
		logic [SLOT_W-1:0]    idx;
		logic                 valid;
		logic [HOLDER_W-1:0]  holder;
		logic [MB_W-1:0]      amount;
	} slot_wr_t;

endpackage
`default_nettype wire

// ===== rtl/core/pdrl_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pdrl_cell (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [pdrl_pkg::SLOT_W-1:0]  cell_idx,
	input  wire pdrl_pkg::srch_t              rec_i,
	output pdrl_pkg::srch_t                   rec_o,
	input  wire pdrl_pkg::slot_wr_t           wr
);

	logic [pdrl_pkg::DEVICES-1:0]                         valid_q;
	logic [pdrl_pkg::DEVICES-1:0][pdrl_pkg::HOLDER_W-1:0] holder_q;
	logic [pdrl_pkg::DEVICES-1:0][pdrl_pkg::MB_W-1:0]     amount_q;
	pdrl_pkg::srch_t                                      rec_q;
	pdrl_pkg::srch_t                                      nxt;
	logic [pdrl_pkg::DEV_IDX_W-1:0]                       d;

	assign d = rec_i.dev;

	// fold this slot into the passing search record
	always_comb begin
		nxt = rec_i;
		if (valid_q[d]) begin
			nxt.cnt = rec_i.cnt + pdrl_pkg::CNT_W'(1);
			if (holder_q[d] == rec_i.who && !rec_i.hit) begin
				nxt.hit     = 1'b1;
				nxt.hit_idx = cell_idx;
				nxt.hit_amt = amount_q[d];
			end
		end else if (!rec_i.free_ok) begin
			nxt.free_ok  = 1'b1;
			nxt.free_idx = cell_idx;
		end
	end

	// hand the record to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else begin
			rec_q <= nxt;
		end
	end

	assign rec_o = rec_q;

	// slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.clr_all) begin
			valid_q <= '0;
		end else if (wr.en && wr.idx == cell_idx) begin
			valid_q[wr.dev] <= wr.valid;
		end
	end

	// slot payload
	always_ff @(posedge clk) begin
		if (!wr.clr_all && wr.en && wr.valid && wr.idx == cell_idx) begin
			holder_q[wr.dev] <= wr.holder;
			amount_q[wr.dev] <= wr.amount;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/pdrl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pdrl_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    opcode,
	input  wire logic [pdrl_pkg::DEV_W-1:0]    device,
	input  wire logic                          holder_present,
	input  wire logic [pdrl_pkg::HOLDER_W-1:0] holder_id,
	input  wire logic [pdrl_pkg::MB_W-1:0]     amount_mb,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               granted,
	output logic [2:0]                         status,
	output logic [pdrl_pkg::MB_W-1:0]          reserved_mb,
	output logic [pdrl_pkg::MB_W-1:0]          free_mb,
	output logic [pdrl_pkg::MB_W-1:0]          capacity_mb,
	output logic [pdrl_pkg::CNT_W-1:0]         holder_count,
	input  wire pdrl_pkg::cap_arr_t            caps,
	output pdrl_pkg::srch_t                    launch,
	input  wire pdrl_pkg::srch_t               exit_rec,
	output pdrl_pkg::slot_wr_t                 wr
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SEARCH = 5'b00010,
		ST_CALC   = 5'b00100,
		ST_DECIDE = 5'b01000,
		ST_RESP   = 5'b10000
	} state_t;

	state_t                                        state_q;
	pdrl_pkg::op_t                                 op_q;
	logic [pdrl_pkg::DEV_W-1:0]                    dev_q;
	logic                                          pres_q;
	logic [pdrl_pkg::HOLDER_W-1:0]                 who_q;
	logic [pdrl_pkg::MB_W-1:0]                     amt_q;
	logic                                          launch_q;
	logic                                          hit_q;
	logic [pdrl_pkg::SLOT_W-1:0]                   hit_idx_q;
	logic [pdrl_pkg::MB_W-1:0]                     hit_amt_q;
	logic                                          free_ok_q;
	logic [pdrl_pkg::SLOT_W-1:0]                   free_idx_q;
	logic [pdrl_pkg::CNT_W-1:0]                    cnt_q;
	logic [pdrl_pkg::MB_W-1:0]                     base_q;
	logic [pdrl_pkg::MB_W-1:0]                     reltot_q;
	logic [pdrl_pkg::DEVICES-1:0][pdrl_pkg::MB_W-1:0] total_q;
	logic                                          rgrant_q;
	pdrl_pkg::status_t                             rstat_q;
	logic [pdrl_pkg::CNT_W-1:0]                    rcnt_q;
	logic                                          out_valid_q;
	logic                                          granted_q;
	pdrl_pkg::status_t                             status_q;
	logic [pdrl_pkg::MB_W-1:0]                     reserved_q;
	logic [pdrl_pkg::MB_W-1:0]                     free_q;
	logic [pdrl_pkg::MB_W-1:0]                     capacity_q;
	logic [pdrl_pkg::CNT_W-1:0]                    count_q;

	logic                                          dev_ok;
	logic [pdrl_pkg::DEV_IDX_W-1:0]                dev_idx;
	logic [pdrl_pkg::MB_W-1:0]                     cap_sel;
	logic [pdrl_pkg::MB_W-1:0]                     total_sel;
	logic [pdrl_pkg::MB_W-1:0]                     rel_amt;
	logic [pdrl_pkg::MB_W:0]                       sum_w;
	logic                                          tot_we;
	logic                                          tot_clr;
	logic [pdrl_pkg::MB_W-1:0]                     tot_nxt;
	logic                                          d_grant;
	pdrl_pkg::status_t                             d_stat;
	logic [pdrl_pkg::CNT_W-1:0]                    d_cnt;
	logic                                          out_free;

	assign dev_ok    = int'(dev_q) < pdrl_pkg::DEVICES;
	assign dev_idx   = dev_q[pdrl_pkg::DEV_IDX_W-1:0];
	assign cap_sel   = dev_ok ? caps[dev_q] : '0;
	assign total_sel = total_q[dev_idx];
	assign rel_amt   = (hit_amt_q < amt_q) ? hit_amt_q : amt_q;
	assign sum_w     = {1'b0, base_q} + {1'b0, amt_q};
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);

	// search record sent into the first cell
	always_comb begin
		launch          = '0;
		launch.vld      = launch_q;
		launch.dev      = dev_idx;
		launch.who      = who_q;
	end

	// admission decision and ledger update
	always_comb begin
		wr      = '0;
		wr.dev  = dev_idx;
		tot_we  = 1'b0;
		tot_clr = 1'b0;
		tot_nxt = total_sel;
		d_grant = 1'b1;
		d_stat  = pdrl_pkg::STS_OK;
		d_cnt   = cnt_q;
		if (state_q == ST_DECIDE) begin
			if (op_q == pdrl_pkg::OP_CLEAR) begin
				wr.clr_all = 1'b1;
				tot_clr    = 1'b1;
				d_cnt      = '0;
			end else if (dev_ok) begin
				case (op_q)
					pdrl_pkg::OP_RESERVE: begin
						if (!pres_q) begin
							d_grant = 1'b0;
							d_stat  = pdrl_pkg::STS_EMPTY;
						end else if (amt_q != '0 && cap_sel != '0) begin
							if (sum_w > {1'b0, cap_sel}) begin
								d_grant = 1'b0;
								d_stat  = pdrl_pkg::STS_OVER;
							end else if (!hit_q && !free_ok_q) begin
								d_grant = 1'b0;
								d_stat  = pdrl_pkg::STS_FULL;
							end else begin
								wr.en     = 1'b1;
								wr.idx    = hit_q ? hit_idx_q : free_idx_q;
								wr.valid  = 1'b1;
								wr.holder = who_q;
								wr.amount = amt_q;
								tot_we    = 1'b1;
								tot_nxt   = sum_w[pdrl_pkg::MB_W-1:0];
								if (!hit_q) begin
									d_cnt = cnt_q + pdrl_pkg::CNT_W'(1);
								end
							end
						end
					end
					pdrl_pkg::OP_RELEASE: begin
						if (!pres_q) begin
							d_grant = 1'b0;
							d_stat  = pdrl_pkg::STS_EMPTY;
						end else if (!hit_q) begin
							d_grant = 1'b0;
							d_stat  = pdrl_pkg::STS_UNKNOWN;
						end else begin
							wr.en   = 1'b1;
							wr.idx  = hit_idx_q;
							tot_we  = 1'b1;
							tot_nxt = reltot_q;
							d_cnt   = cnt_q - pdrl_pkg::CNT_W'(1);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			launch_q <= 1'b0;
		end else begin
			launch_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q  <= ST_SEARCH;
						launch_q <= 1'b1;
					end
				end
				ST_SEARCH: begin
					if (exit_rec.vld) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC:   state_q <= ST_DECIDE;
				ST_DECIDE: state_q <= ST_RESP;
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// request capture and search results
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= pdrl_pkg::op_t'(opcode);
			dev_q  <= device;
			pres_q <= holder_present;
			who_q  <= holder_id;
			amt_q  <= amount_mb;
		end
		if (state_q == ST_SEARCH && exit_rec.vld) begin
			hit_q      <= exit_rec.hit;
			hit_idx_q  <= exit_rec.hit_idx;
			hit_amt_q  <= exit_rec.hit_amt;
			free_ok_q  <= exit_rec.free_ok;
			free_idx_q <= exit_rec.free_idx;
			cnt_q      <= exit_rec.cnt;
		end
		// base without the holder's old amount, and the post-release total
		if (state_q == ST_CALC) begin
			if (hit_q) begin
				base_q <= (total_sel >= hit_amt_q) ? total_sel - hit_amt_q : '0;
			end else begin
				base_q <= total_sel;
			end
			reltot_q <= (total_sel > rel_amt) ? total_sel - rel_amt : '0;
		end
		if (state_q == ST_DECIDE) begin
			rgrant_q <= d_grant;
			rstat_q  <= d_stat;
			rcnt_q   <= d_cnt;
		end
	end

	// per-device reserved totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (tot_clr) begin
			total_q <= '0;
		end else if (tot_we) begin
			total_q[dev_idx] <= tot_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && out_free) begin
			granted_q  <= rgrant_q;
			status_q   <= rstat_q;
			capacity_q <= cap_sel;
			if (dev_ok) begin
				reserved_q <= total_sel;
				free_q     <= (cap_sel != '0 && cap_sel > total_sel) ?
				              cap_sel - total_sel : '0;
				count_q    <= rcnt_q;
			end else begin
				reserved_q <= '0;
				free_q     <= '0;
				count_q    <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign granted      = granted_q;
	assign status       = status_q;
	assign reserved_mb  = reserved_q;
	assign free_mb      = free_q;
	assign capacity_mb  = capacity_q;
	assign holder_count = count_q;

	// search results come back only while waiting for them
	a_exit_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		exit_rec.vld |-> state_q == ST_SEARCH)
		else $error("search record left the chain outside the search phase");

	// slots change only at the decision step
	a_write_in_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.en || wr.clr_all) |-> state_q == ST_DECIDE)
		else $error("slot update outside the decision step");

	// a refused transaction never reports ok
	a_refusal_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !granted) |-> status != pdrl_pkg::STS_OK)
		else $error("refused transaction with ok status");

	// holder count bounded by the slot table
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> int'(holder_count) <= pdrl_pkg::HOLDER_SLOTS)
		else $error("holder count above slot table size");

endmodule
`default_nettype wire

// ===== rtl/core/per_device_reservation_ledger_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Per-device reservation ledger.
// Input channel (in_valid/in_ready) takes one request transaction: opcode,
// device, holder_present, holder_id, amount_mb. Output channel
// (out_valid/out_ready) returns exactly one result transaction per request:
// granted, status and the addressed device's reserved, free and capacity
// values with its holder count.
// Capacities are written through the APB-style port, register i at byte
// address 4*i; pready is always high and reads return the capacity.
// Each request runs one search pass down a chain of HOLDER_SLOTS cells, one
// cell per cycle, followed by a calculate, a decide and a respond step.
// Only one request is in flight at a time: a new request is taken only
// once the previous one has left its respond step.
// Reset clears every holder slot, all reserved totals and the capacities;
// no clearing pass is needed. A stalled receiver holds the result in the
// output register; the next request may already be taken and waits at its
// respond step until the register frees.
module per_device_reservation_ledger_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pdrl_pkg::CFG_AW-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    opcode,
	input  wire logic [pdrl_pkg::DEV_W-1:0]    device,
	input  wire logic                          holder_present,
	input  wire logic [pdrl_pkg::HOLDER_W-1:0] holder_id,
	input  wire logic [pdrl_pkg::MB_W-1:0]     amount_mb,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               granted,
	output logic [2:0]                         status,
	output logic [pdrl_pkg::MB_W-1:0]          reserved_mb,
	output logic [pdrl_pkg::MB_W-1:0]          free_mb,
	output logic [pdrl_pkg::MB_W-1:0]          capacity_mb,
	output logic [pdrl_pkg::CNT_W-1:0]         holder_count
);

	pdrl_pkg::cap_arr_t  cap_q;
	pdrl_pkg::srch_t     chain [pdrl_pkg::HOLDER_SLOTS+1];
	pdrl_pkg::slot_wr_t  wr;
	logic [1:0]          reg_idx;

	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign prdata  = {{(32-pdrl_pkg::MB_W){1'b0}}, cap_q[reg_idx]};

	// capacity registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			cap_q[reg_idx] <= pwdata[pdrl_pkg::MB_W-1:0];
		end
	end

	pdrl_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.device         (device),
		.holder_present (holder_present),
		.holder_id      (holder_id),
		.amount_mb      (amount_mb),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.granted        (granted),
		.status         (status),
		.reserved_mb    (reserved_mb),
		.free_mb        (free_mb),
		.capacity_mb    (capacity_mb),
		.holder_count   (holder_count),
		.caps           (cap_q),
		.launch         (chain[0]),
		.exit_rec       (chain[pdrl_pkg::HOLDER_SLOTS]),
		.wr             (wr)
	);

	// one cell per holder slot, search record moves one cell a cycle
	for (genvar i = 0; i < pdrl_pkg::HOLDER_SLOTS; i++) begin : g_cell
		pdrl_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (pdrl_pkg::SLOT_W'(i)),
			.rec_i    (chain[i]),
			.rec_o    (chain[i+1]),
			.wr       (wr)
		);
	end

endmodule
`default_nettype wire
